// ===== src/opl_pkg.sv =====
// shared constants, codes and types for the ordered position list
`timescale 1ns / 1ps

package opl_pkg;

   // default sizing
   localparam int CAPACITY_DEF   = 64;
   localparam int WORD_WIDTH_DEF = 32;

   // fixed field widths
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DEL_POS   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_READ      = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic ins;
      logic del;
   } opl_cmd_type;

endpackage

// ===== src/ordered_position_list.sv =====
// ordered position list: top level with request decode and the cell row
//
// Usage:
//   req channel (req_valid/req_ready) carries one transaction: kind, value,
//   position. Kinds insert at front, back or a 1-based position, delete at
//   front, back or a position, or read the entry at a position.
//   rsp channel (rsp_valid/rsp_ready) returns one transaction per request:
//   status (ok, bad position, empty, full), the count after the request and
//   the word read (zero unless an ok read).
// Response: registered; it shows in the cycle after acceptance.
// Throughput: one transaction per cycle while rsp_ready is high; the whole
//   row of cells shifts at once, and the response register is the only stage.
// Stall: while a response waits for rsp_ready, req_ready stays low unless
//   the response is taken in the same cycle; nothing is lost or repeated.
// Reset: synchronous, active high; clears the count and the response valid.
//   Stored words are not cleared, since only entries below the count are read.
`timescale 1ns / 1ps

module ordered_position_list
   import opl_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   localparam int CNT_W     = $clog2(CAPACITY + 1),
   localparam int IDX_W     = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CNT_W-1:0]    rsp_count,
   output logic [VALUE_W-1:0]  rsp_read_value
);

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic [VALUE_W-1:0]  rsp_read_value_ff;

   logic                accept;
   opl_cmd_type         cmd;
   logic [IDX_W-1:0]    idx;
   logic [STATUS_W-1:0] status;
   logic                read_ok;
   logic                full;
   logic                empty;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic                pos_ok_ins;
   logic                pos_ok_del;
   logic [IDX_W-1:0]    pos_idx;
   logic [WORD_WIDTH-1:0] new_word;
   logic [WORD_WIDTH-1:0] rd_word;
   logic [VALUE_W-1:0]  read_value;

   logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
   logic [WORD_WIDTH-1:0] cell_sel  [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign pos_ext    = CMP_W'(req_position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign pos_ok_del = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign pos_idx    = IDX_W'(pos_ext - CMP_W'(1));
   assign new_word   = WORD_WIDTH'(req_value);

   always_comb begin
      cmd      = '0;
      idx      = pos_idx;
      status   = ST_OK;
      read_ok  = 1'b0;
      count_in = count_ff;
      case (req_kind)
         KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
            if (req_kind == KIND_INS_FRONT) begin
               idx = '0;
            end else if (req_kind == KIND_INS_BACK) begin
               idx = IDX_W'(count_ff);
            end
            if (full) begin
               status = ST_FULL;
            end else if (req_kind == KIND_INS_POS && !pos_ok_ins) begin
               status = ST_BADPOS;
            end else begin
               cmd.ins  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_POS: begin
            if (req_kind == KIND_DEL_FRONT) begin
               idx = '0;
            end else if (req_kind == KIND_DEL_BACK) begin
               idx = IDX_W'(count_ff - CNT_W'(1));
            end
            if (empty) begin
               status = ST_EMPTY;
            end else if (req_kind == KIND_DEL_POS && !pos_ok_del) begin
               status = ST_BADPOS;
            end else begin
               cmd.del  = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         KIND_READ: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (!pos_ok_del) begin
               status = ST_BADPOS;
            end else begin
               read_ok = 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (!accept) begin
         cmd      = '0;
         count_in = count_ff;
      end
   end

   // the addressed cell drives its word, all others give zero
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | cell_sel[i];
      end
   end

   assign read_value = read_ok ? VALUE_W'(rd_word) : '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;

      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = cell_word[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = cell_word[g+1];
      end

      opl_cell #(
         .WORD_WIDTH(WORD_WIDTH),
         .IDX_W     (IDX_W),
         .CELL_IDX  (g)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .idx       (idx),
         .new_word  (new_word),
         .left_word (left_word),
         .right_word(right_word),
         .word      (cell_word[g]),
         .sel_word  (cell_sel[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= status;
         rsp_count_ff      <= count_in;
         rsp_read_value_ff <= read_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

// ===== src/opl_cell.sv =====
// one storage cell of the list row: holds a word, shifts with its neighbors
`timescale 1ns / 1ps

module opl_cell
   import opl_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   parameter int IDX_W      = 6,
   parameter int CELL_IDX   = 0
) (
   input  logic                  clock,
   input  opl_cmd_type           cmd,
   input  logic [IDX_W-1:0]      idx,
   input  logic [WORD_WIDTH-1:0] new_word,
   input  logic [WORD_WIDTH-1:0] left_word,
   input  logic [WORD_WIDTH-1:0] right_word,
   output logic [WORD_WIDTH-1:0] word,
   output logic [WORD_WIDTH-1:0] sel_word
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.ins) begin
         if (MY_IDX == idx) begin
            word_in = new_word;
         end else if (MY_IDX > idx) begin
            word_in = left_word;
         end
      end else if (cmd.del) begin
         // close the gap from the right
         if (MY_IDX >= idx) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word     = word_ff;
   assign sel_word = (MY_IDX == idx) ? word_ff : '0;

endmodule

// ===== src/opl_checker.sv =====
// port-level checks for the ordered position list, bound to the top level
`timescale 1ns / 1ps

module opl_checker
   import opl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [CNT_W-1:0]    rsp_count,
   input logic [VALUE_W-1:0]  rsp_read_value
);

   // count never goes past the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CNT_W'(CAPACITY))
      else $error("response count exceeds capacity");

   // a full status only comes from a list at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == CNT_W'(CAPACITY))
      else $error("full status with count below capacity");

   // an empty status only comes from an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
      else $error("empty status with nonzero count");

   // a failed transaction returns no data
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("read data on a failed transaction");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_count) && $stable(rsp_read_value))
      else $error("stalled response changed");

endmodule

bind ordered_position_list opl_checker #(.CAPACITY(CAPACITY)) u_opl_checker (.*);
